### rtl/tcps_pkg.sv
// ----------------------------------------------------------------------------
// tcps_pkg
// shared constants, codes and types of the two-class priority server
// ----------------------------------------------------------------------------
package tcps_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 128;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // queue entry: arrival time in the high bits, service time in the low bits
   localparam int TIME_W    = 32;
   localparam int SERVICE_W = 16;
   localparam int ENTRY_W   = TIME_W + SERVICE_W;
   localparam int TOTAL_W   = 48;
   localparam int COUNT_W   = 32;

   // request operation codes
   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // response status codes
   typedef enum logic [1:0] {
      ST_ACCEPTED  = 2'd0,
      ST_DROPPED   = 2'd1,
      ST_STARTED   = 2'd2,
      ST_IDLE_TICK = 2'd3
   } status_type;

   // queue control and status
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

### rtl/tcps_fifo.sv
// ----------------------------------------------------------------------------
// tcps_fifo
// one job queue: circular buffer in a synchronous memory with head and fill count
// ----------------------------------------------------------------------------
module tcps_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  tcps_pkg::fifo_ctl_type            ctl,
   input  logic [tcps_pkg::ENTRY_W-1:0]      push_data,
   output tcps_pkg::fifo_stat_type           stat,
   output logic [tcps_pkg::ENTRY_W-1:0]      pop_data
);
   import tcps_pkg::*;

   localparam int SUM_W = PTR_W + 1;

   logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]   slot_sum;
   logic [PTR_W-1:0]   slot;
   logic               do_push;
   logic               do_pop;

   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = ctl.push && !stat.full;
   assign do_pop     = ctl.pop && !stat.empty;

   // tail slot, wrapped without a modulo
   assign slot_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign slot     = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     PTR_W'(slot_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(slot_sum);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (do_pop) begin
         head_in  = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (do_push) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[slot] <= push_data;
      end
      if (do_pop) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign pop_data = rd_data_ff;

endmodule

### rtl/two_class_priority_server_top.sv
// ----------------------------------------------------------------------------
// two_class_priority_server_top
// single server fed by a priority and a regular job queue, strict priority
// ----------------------------------------------------------------------------
// usage
//   req channel (valid/ready): op 0 is an arrival that queues one job of the
//   given class with its arrival time and service time; op 1 is a time tick
//   rsp channel (valid/ready): exactly one response per request, in order,
//   carrying the status, the started job's class and wait, the time before
//   the request and the running wait totals and served counts
//   one request is in flight at a time; the job queues live in two
//   synchronous memories with a registered read port
//   steps per request: an arrival loads the response; a tick without a start
//   updates time, then loads the response; a tick that starts a job runs head
//   read, wait subtract, 48-bit saturating totals update, response load
//   the response is registered and appears the cycle after the last step
//   if the receiver stalls, the response is held and the block waits in its
//   final step; req_ready stays low until the response register frees up
//   reset (synchronous, active high) empties both queues and clears time,
//   totals and counts; queue memory contents are not cleared (no clearing
//   pass, a queue entry is only read after it has been written)
// ----------------------------------------------------------------------------
module two_class_priority_server_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_op,
   input  logic                             req_is_priority,
   input  logic [tcps_pkg::TIME_W-1:0]      req_arrival_time,
   input  logic [tcps_pkg::SERVICE_W-1:0]   req_service_time,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_started_class,
   output logic [tcps_pkg::TIME_W-1:0]      rsp_job_wait,
   output logic [tcps_pkg::TIME_W-1:0]      rsp_now,
   output logic [tcps_pkg::TOTAL_W-1:0]     rsp_regular_wait_total,
   output logic [tcps_pkg::TOTAL_W-1:0]     rsp_priority_wait_total,
   output logic [tcps_pkg::COUNT_W-1:0]     rsp_regular_served,
   output logic [tcps_pkg::COUNT_W-1:0]     rsp_priority_served
);
   import tcps_pkg::*;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_READ   = 4'b0010,
      S_UPDATE = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // queue interfaces
   fifo_ctl_type       reg_ctl, pri_ctl;
   fifo_stat_type      reg_stat, pri_stat;
   logic [ENTRY_W-1:0] reg_data, pri_data, push_data;

   // per-request registers
   status_type           status_ff, status_in;
   logic                 class_ff, class_in;
   logic                 start_ff, start_in;
   logic [TIME_W-1:0]    job_wait_ff, job_wait_in;
   logic [SERVICE_W-1:0] service_ff, service_in;
   logic [TIME_W-1:0]    now_before_ff, now_before_in;

   // server state
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [TIME_W:0]      free_at_ff, free_at_in;
   logic [TOTAL_W-1:0]   reg_sum_ff, reg_sum_in;
   logic [TOTAL_W-1:0]   pri_sum_ff, pri_sum_in;
   logic [COUNT_W-1:0]   reg_done_ff, reg_done_in;
   logic [COUNT_W-1:0]   pri_done_ff, pri_done_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_class_ff, rsp_class_in;
   logic [TIME_W-1:0]    rsp_wait_ff, rsp_wait_in;
   logic [TIME_W-1:0]    rsp_now_ff, rsp_now_in;
   logic [TOTAL_W-1:0]   rsp_reg_sum_ff, rsp_reg_sum_in;
   logic [TOTAL_W-1:0]   rsp_pri_sum_ff, rsp_pri_sum_in;
   logic [COUNT_W-1:0]   rsp_reg_done_ff, rsp_reg_done_in;
   logic [COUNT_W-1:0]   rsp_pri_done_ff, rsp_pri_done_in;

   // datapath helpers
   logic                 req_fire;
   logic                 can_start;
   logic                 rsp_free;
   logic [ENTRY_W-1:0]   head_entry;
   logic [TIME_W-1:0]    head_arrival;
   logic [TOTAL_W:0]     sum_wide;
   logic [TOTAL_W-1:0]   sum_base;
   logic [TIME_W:0]      free_next;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign push_data = {req_arrival_time, req_service_time};

   // server free and at least one job waiting
   assign can_start = ({1'b0, now_ff} >= free_at_ff) && (!pri_stat.empty || !reg_stat.empty);

   // queue commands: pushes and pops both happen on the accept edge
   always_comb begin
      reg_ctl = '0;
      pri_ctl = '0;
      if (req_fire) begin
         if (req_op == OP_ARRIVAL) begin
            pri_ctl.push = req_is_priority;
            reg_ctl.push = !req_is_priority;
         end else if (can_start) begin
            pri_ctl.pop = !pri_stat.empty;
            reg_ctl.pop = pri_stat.empty;
         end
      end
   end

   tcps_fifo u_regular_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (reg_ctl),
      .push_data (push_data),
      .stat      (reg_stat),
      .pop_data  (reg_data)
   );

   tcps_fifo u_priority_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pri_ctl),
      .push_data (push_data),
      .stat      (pri_stat),
      .pop_data  (pri_data)
   );

   assign head_entry   = class_ff ? pri_data : reg_data;
   assign head_arrival = head_entry[ENTRY_W-1:SERVICE_W];

   // saturating wait total update, shared by both classes
   assign sum_base  = class_ff ? pri_sum_ff : reg_sum_ff;
   assign sum_wide  = {1'b0, sum_base} + (TOTAL_W + 1)'(job_wait_ff);
   assign free_next = start_ff ? ({1'b0, now_ff} + (TIME_W + 1)'(service_ff)) : free_at_ff;

   always_comb begin
      state_in        = state_ff;
      status_in       = status_ff;
      class_in        = class_ff;
      start_in        = start_ff;
      job_wait_in     = job_wait_ff;
      service_in      = service_ff;
      now_before_in   = now_before_ff;
      now_in          = now_ff;
      free_at_in      = free_at_ff;
      reg_sum_in      = reg_sum_ff;
      pri_sum_in      = pri_sum_ff;
      reg_done_in     = reg_done_ff;
      pri_done_in     = pri_done_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_class_in    = rsp_class_ff;
      rsp_wait_in     = rsp_wait_ff;
      rsp_now_in      = rsp_now_ff;
      rsp_reg_sum_in  = rsp_reg_sum_ff;
      rsp_pri_sum_in  = rsp_pri_sum_ff;
      rsp_reg_done_in = rsp_reg_done_ff;
      rsp_pri_done_in = rsp_pri_done_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               now_before_in = now_ff;
               job_wait_in   = '0;
               if (req_op == OP_ARRIVAL) begin
                  class_in = 1'b0;
                  start_in = 1'b0;
                  if (req_is_priority ? pri_stat.full : reg_stat.full) begin
                     status_in = ST_DROPPED;
                  end else begin
                     status_in = ST_ACCEPTED;
                  end
                  state_in = S_FINISH;
               end else begin
                  start_in  = can_start;
                  class_in  = can_start && !pri_stat.empty;
                  status_in = can_start ? ST_STARTED : ST_IDLE_TICK;
                  state_in  = can_start ? S_READ : S_UPDATE;
               end
            end
         end
         S_READ: begin
            // head entry has arrived from memory; late arrivals wait zero
            job_wait_in = (now_ff > head_arrival) ? (now_ff - head_arrival) : '0;
            service_in  = head_entry[SERVICE_W-1:0];
            state_in    = S_UPDATE;
         end
         S_UPDATE: begin
            if (start_ff) begin
               if (class_ff) begin
                  pri_sum_in  = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
                  pri_done_in = (pri_done_ff == '1) ? pri_done_ff : pri_done_ff + 1'b1;
               end else begin
                  reg_sum_in  = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
                  reg_done_in = (reg_done_ff == '1) ? reg_done_ff : reg_done_ff + 1'b1;
               end
            end
            // time wrap keeps the remaining busy time
            if (now_ff == '1) begin
               now_in     = '0;
               free_at_in = free_next[TIME_W] ? {1'b0, free_next[TIME_W-1:0]} : '0;
            end else begin
               now_in     = now_ff + 1'b1;
               free_at_in = free_next;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_class_in    = class_ff;
               rsp_wait_in     = job_wait_ff;
               rsp_now_in      = now_before_ff;
               rsp_reg_sum_in  = reg_sum_ff;
               rsp_pri_sum_in  = pri_sum_ff;
               rsp_reg_done_in = reg_done_ff;
               rsp_pri_done_in = pri_done_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         now_ff       <= '0;
         free_at_ff   <= '0;
         reg_sum_ff   <= '0;
         pri_sum_ff   <= '0;
         reg_done_ff  <= '0;
         pri_done_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         now_ff       <= now_in;
         free_at_ff   <= free_at_in;
         reg_sum_ff   <= reg_sum_in;
         pri_sum_ff   <= pri_sum_in;
         reg_done_ff  <= reg_done_in;
         pri_done_ff  <= pri_done_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff       <= status_in;
      class_ff        <= class_in;
      start_ff        <= start_in;
      job_wait_ff     <= job_wait_in;
      service_ff      <= service_in;
      now_before_ff   <= now_before_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_class_ff    <= rsp_class_in;
      rsp_wait_ff     <= rsp_wait_in;
      rsp_now_ff      <= rsp_now_in;
      rsp_reg_sum_ff  <= rsp_reg_sum_in;
      rsp_pri_sum_ff  <= rsp_pri_sum_in;
      rsp_reg_done_ff <= rsp_reg_done_in;
      rsp_pri_done_ff <= rsp_pri_done_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = rsp_status_ff;
   assign rsp_started_class       = rsp_class_ff;
   assign rsp_job_wait            = rsp_wait_ff;
   assign rsp_now                 = rsp_now_ff;
   assign rsp_regular_wait_total  = rsp_reg_sum_ff;
   assign rsp_priority_wait_total = rsp_pri_sum_ff;
   assign rsp_regular_served      = rsp_reg_done_ff;
   assign rsp_priority_served     = rsp_pri_done_ff;

`ifndef SYNTHESIS
   // a pop is only ever issued to a queue holding a job
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      !(reg_ctl.pop && reg_stat.empty) && !(pri_ctl.pop && pri_stat.empty))
      else $error("pop issued to an empty queue");

   // wait totals never go backwards
   a_sum_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (reg_sum_ff >= $past(reg_sum_ff)) && (pri_sum_ff >= $past(pri_sum_ff)))
      else $error("wait total decreased");

   // only a started job reports a class or a wait
   a_no_start_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_STARTED) |->
         (rsp_wait_ff == '0) && !rsp_class_ff)
      else $error("class or wait reported without a start");
`endif

endmodule
